// File: design/sphere_bounce_reflect_top_assert.svh
// ----------------------------------------------------------------------------
// sphere_bounce_reflect_top_assert.svh
// Assertion macros for the sphere bounce block. Sampled on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SPHERE_BOUNCE_REFLECT_TOP_ASSERT_SVH
`define SPHERE_BOUNCE_REFLECT_TOP_ASSERT_SVH

// Same-cycle implication.
`define SBR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbr: same-cycle check failed");

// Next-cycle implication.
`define SBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbr: next-cycle check failed");

`endif

// File: design/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg
// Shared types, constants and helpers of the sphere bounce pipeline.
// ----------------------------------------------------------------------------
package sbr_pkg;

  localparam int SQ_STEPS  = 32;  // one root bit per stage
  localparam int DIV_STEPS = 31;  // one quotient bit per stage

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_CENTER_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS   = 3'd3;
  localparam logic [2:0] REG_DAMPING  = 3'd4;

  localparam logic [17:0] DAMP_RESET = 18'd65536;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0]       nneg;
    logic             hit;
  } item_t;

  typedef struct packed {
    item_t            item;
    logic [63:0]      x;     // radicand, consumed two bits per stage
    logic [35:0]      rem;
    logic [31:0]      root;
    logic [2:0][30:0] nmag;
    logic [2:0][61:0] rn;    // radius * |n|
  } sq_t;

  typedef struct packed {
    item_t            item;
    logic [30:0]      d;
    logic [5:0][30:0] rem;
    logic [5:0][30:0] lo;
    logic [5:0][30:0] quo;
  } dv_t;

  typedef struct packed {
    logic [2:0][31:0] new_pos;
    logic [2:0][31:0] new_vel;
    logic             bounced;
  } out_t;

  function automatic logic [31:0] sat33(input logic [32:0] x);
    logic [31:0] r;
    if (x[32] == x[31]) r = x[31:0];
    else r = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    return r;
  endfunction

  function automatic logic [31:0] sat39(input logic [38:0] x);
    logic [31:0] r;
    if (x[38:31] == {8{x[31]}}) r = x[31:0];
    else r = x[38] ? 32'h8000_0000 : 32'h7fff_ffff;
    return r;
  endfunction

endpackage

// File: design/sbr_front.sv
// ----------------------------------------------------------------------------
// sbr_front
// Offset, squares and dot products, then the inside and inward test.
// ----------------------------------------------------------------------------
module sbr_front import sbr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [2:0][31:0] pos,
  input  logic [2:0][31:0] vel,
  input  logic [2:0][31:0] center,
  input  logic [30:0]      radius,
  output logic             out_valid,
  output sq_t              out_d
);

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0][32:0] n;
  } f1_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic [2:0]       nneg;
    logic             inr;
    logic [2:0][30:0] nmag;
    logic [2:0][61:0] sq;
    logic [2:0][64:0] nv;
    logic [2:0][61:0] rn;
    logic [61:0]      rad2;
  } f2_t;

  f1_t f1_r, f1_nxt;
  f2_t f2_r, f2_nxt;
  sq_t f3_r, f3_nxt;
  logic v1_r, v2_r, v3_r;
  logic [2:0][32:0] mag;
  logic [63:0] r2;
  logic signed [66:0] dot;

  always_comb begin
    f1_nxt.p = pos;
    f1_nxt.v = vel;
    for (int i = 0; i < 3; i++) begin
      f1_nxt.n[i] = {pos[i][31], pos[i]} - {center[i][31], center[i]};
    end
  end

  always_comb begin
    f2_nxt.p    = f1_r.p;
    f2_nxt.v    = f1_r.v;
    f2_nxt.inr  = 1'b1;
    f2_nxt.rad2 = 62'(radius * radius);
    for (int i = 0; i < 3; i++) begin
      mag[i]         = f1_r.n[i][32] ? 33'(33'd0 - f1_r.n[i]) : f1_r.n[i];
      f2_nxt.nneg[i] = f1_r.n[i][32];
      // offsets of 2^31 or more can never lie inside
      if (mag[i][32:31] != 2'b00) f2_nxt.inr = 1'b0;
      f2_nxt.nmag[i] = mag[i][30:0];
      f2_nxt.sq[i]   = 62'(mag[i][30:0] * mag[i][30:0]);
      f2_nxt.rn[i]   = 62'(radius * mag[i][30:0]);
      f2_nxt.nv[i]   = 65'($signed(f1_r.n[i]) * $signed(f1_r.v[i]));
    end
  end

  always_comb begin
    r2  = 64'(f2_r.sq[0]) + 64'(f2_r.sq[1]) + 64'(f2_r.sq[2]);
    dot = 67'($signed(f2_r.nv[0])) + 67'($signed(f2_r.nv[1])) +
          67'($signed(f2_r.nv[2]));
    f3_nxt.item.p    = f2_r.p;
    f3_nxt.item.v    = f2_r.v;
    f3_nxt.item.nneg = f2_r.nneg;
    f3_nxt.item.hit  = f2_r.inr && (64'(f2_r.rad2) > r2) && dot[66];
    f3_nxt.x         = r2;
    f3_nxt.rem       = '0;
    f3_nxt.root      = '0;
    f3_nxt.nmag      = f2_r.nmag;
    f3_nxt.rn        = f2_r.rn;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
      f3_r <= f3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_d     = f3_r;

endmodule

// File: design/sbr_sqrt_stage.sv
// ----------------------------------------------------------------------------
// sbr_sqrt_stage
// One step of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module sbr_sqrt_stage import sbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  sq_t  in_d,
  output logic out_valid,
  output sq_t  out_d
);

  sq_t st_r, st_nxt;
  logic valid_r;
  logic [35:0] rem_t, trial;
  logic ge;

  always_comb begin
    rem_t  = {in_d.rem[33:0], in_d.x[63:62]};
    trial  = {2'b00, in_d.root, 2'b01};
    ge     = rem_t >= trial;
    st_nxt = in_d;
    st_nxt.x    = {in_d.x[61:0], 2'b00};
    st_nxt.rem  = ge ? rem_t - trial : rem_t;
    st_nxt.root = {in_d.root[30:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = st_r;

endmodule

// File: design/sbr_div_stage.sv
// ----------------------------------------------------------------------------
// sbr_div_stage
// One restoring-division step for all six lanes sharing the divisor r.
// ----------------------------------------------------------------------------
module sbr_div_stage import sbr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  dv_t  in_d,
  output logic out_valid,
  output dv_t  out_d
);

  dv_t st_r, st_nxt;
  logic valid_r;
  logic [5:0][31:0] t;
  logic [5:0] ge;

  always_comb begin
    st_nxt = in_d;
    for (int j = 0; j < 6; j++) begin
      t[j]  = {in_d.rem[j], in_d.lo[j][30]};
      ge[j] = t[j] >= {1'b0, in_d.d};
      st_nxt.rem[j] = ge[j] ? 31'(t[j] - {1'b0, in_d.d}) : t[j][30:0];
      st_nxt.lo[j]  = {in_d.lo[j][29:0], 1'b0};
      st_nxt.quo[j] = {in_d.quo[j][29:0], ge[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_d     = st_r;

endmodule

// File: design/sbr_back.sv
// ----------------------------------------------------------------------------
// sbr_back
// Unit vector, reflection, damping, push-out and saturation; output register.
// ----------------------------------------------------------------------------
module sbr_back import sbr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  dv_t              in_d,
  input  logic [2:0][31:0] center,
  input  logic [17:0]      damping,
  output logic             out_valid,
  output out_t             out_d
);

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] v;
    logic             hit;
    logic [2:0][31:0] u;
    logic [2:0][32:0] pos;
    logic [2:0][63:0] vu;
    logic [33:0]      vn;    // up to 3 * 2^31 in magnitude
    logic [2:0][64:0] m;
    logic [2:0][35:0] w;
    logic [2:0][54:0] wd;
  } bk_t;

  bk_t b_r [1:6];
  bk_t b_nxt [1:6];
  logic [6:1] bv_r;
  out_t out_r, out_nxt;
  logic out_valid_r;
  logic [2:0][32:0] qs;
  logic signed [65:0] s;
  logic [65:0] s_adj;
  logic [2:0][64:0] m_adj;
  logic [2:0][54:0] wd_adj;

  // signs back on, center offset added
  always_comb begin
    b_nxt[1]     = '0;
    b_nxt[1].p   = in_d.item.p;
    b_nxt[1].v   = in_d.item.v;
    b_nxt[1].hit = in_d.item.hit;
    for (int i = 0; i < 3; i++) begin
      b_nxt[1].u[i] = in_d.item.nneg[i] ? 32'(32'd0 - {1'b0, in_d.quo[i]})
                                        : {1'b0, in_d.quo[i]};
      qs[i] = in_d.item.nneg[i] ? 33'(33'd0 - {2'b00, in_d.quo[3+i]})
                                : {2'b00, in_d.quo[3+i]};
      b_nxt[1].pos[i] = {center[i][31], center[i]} + qs[i];
    end
  end

  always_comb begin
    b_nxt[2] = b_r[1];
    for (int i = 0; i < 3; i++) begin
      b_nxt[2].vu[i] = 64'($signed(b_r[1].v[i]) * $signed(b_r[1].u[i]));
    end
  end

  // vn = (v . u) / 2^30, truncated toward zero
  always_comb begin
    b_nxt[3]    = b_r[2];
    s           = 66'($signed(b_r[2].vu[0])) + 66'($signed(b_r[2].vu[1])) +
                  66'($signed(b_r[2].vu[2]));
    s_adj       = s + (s[65] ? 66'((66'd1 << 30) - 66'd1) : 66'd0);
    b_nxt[3].vn = s_adj[63:30];
  end

  always_comb begin
    b_nxt[4] = b_r[3];
    for (int i = 0; i < 3; i++) begin
      b_nxt[4].m[i] = 65'($signed(b_r[3].vn) * $signed(b_r[3].u[i]));
    end
  end

  always_comb begin
    b_nxt[5] = b_r[4];
    for (int i = 0; i < 3; i++) begin
      m_adj[i] = b_r[4].m[i] +
                 (b_r[4].m[i][64] ? 65'((65'd1 << 29) - 65'd1) : 65'd0);
      b_nxt[5].w[i] = 36'($signed(b_r[4].v[i])) - m_adj[i][64:29];
    end
  end

  always_comb begin
    b_nxt[6] = b_r[5];
    for (int i = 0; i < 3; i++) begin
      b_nxt[6].wd[i] = 55'($signed(b_r[5].w[i]) * $signed({1'b0, damping}));
    end
  end

  always_comb begin
    out_nxt.bounced = b_r[6].hit;
    for (int i = 0; i < 3; i++) begin
      wd_adj[i] = b_r[6].wd[i] +
                  (b_r[6].wd[i][54] ? 55'((55'd1 << 16) - 55'd1) : 55'd0);
      out_nxt.new_pos[i] = b_r[6].hit ? sat33(b_r[6].pos[i]) : b_r[6].p[i];
      out_nxt.new_vel[i] = b_r[6].hit ? sat39(wd_adj[i][54:16]) : b_r[6].v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      bv_r        <= {bv_r[5:1], in_valid};
      out_valid_r <= bv_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= 6; k++) begin
        b_r[k] <= b_nxt[k];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_d     = out_r;

endmodule

// File: design/sphere_bounce_reflect_top.sv
// Pipeline: 3 front, 32 root, 31 divide, 6 back stages and 1 output register
//   lie between input transaction and result.
// Throughput: one transaction per cycle; the whole pipeline holds while a
//   result waits at the output, so in_ready follows out_ready.
// Reset: synchronous active-low rst_n clears all valid bits and restores the
//   registers (center 0, radius 0, damping 1.0).
// ----------------------------------------------------------------------------
// sphere_bounce_reflect_top
// Reflects a particle off the inside of a configured sphere, Q16.16.
// ----------------------------------------------------------------------------
`include "sphere_bounce_reflect_top_assert.svh"

module sphere_bounce_reflect_top import sbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_vel_x,
  input  logic [31:0] in_vel_y,
  input  logic [31:0] in_vel_z,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_new_pos_x,
  output logic [31:0] out_new_pos_y,
  output logic [31:0] out_new_pos_z,
  output logic [31:0] out_new_vel_x,
  output logic [31:0] out_new_vel_y,
  output logic [31:0] out_new_vel_z,
  output logic        out_bounced
);

  logic [2:0][31:0] center_r;
  logic [30:0] sph_rad_r;
  logic [17:0] damping_r;
  logic wr;
  logic adv;

  sq_t sq_d [0:SQ_STEPS];
  logic [SQ_STEPS:0] sq_v;
  dv_t dv_d [0:DIV_STEPS];
  logic [DIV_STEPS:0] dv_v;
  out_t res;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r  <= '0;
      sph_rad_r <= '0;
      damping_r <= DAMP_RESET;
    end else if (wr) begin
      case (paddr[4:2])
        REG_CENTER_X: center_r[0] <= pwdata;
        REG_CENTER_Y: center_r[1] <= pwdata;
        REG_CENTER_Z: center_r[2] <= pwdata;
        REG_RADIUS:   sph_rad_r   <= pwdata[30:0];
        REG_DAMPING:  damping_r   <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_CENTER_X: prdata = center_r[0];
      REG_CENTER_Y: prdata = center_r[1];
      REG_CENTER_Z: prdata = center_r[2];
      REG_RADIUS:   prdata = {1'b0, sph_rad_r};
      REG_DAMPING:  prdata = {14'd0, damping_r};
      default:      prdata = '0;
    endcase
  end

  // advance everything unless a result is held at the output
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  sbr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (in_valid),
    .pos       ({in_pos_z, in_pos_y, in_pos_x}),
    .vel       ({in_vel_z, in_vel_y, in_vel_x}),
    .center    (center_r),
    .radius    (sph_rad_r),
    .out_valid (sq_v[0]),
    .out_d     (sq_d[0])
  );

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    sbr_sqrt_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (sq_v[k]),
      .in_d      (sq_d[k]),
      .out_valid (sq_v[k+1]),
      .out_d     (sq_d[k+1])
    );
  end

  // divide |n|*2^30 and radius*|n| by r
  always_comb begin
    dv_d[0].item = sq_d[SQ_STEPS].item;
    dv_d[0].d    = sq_d[SQ_STEPS].root[30:0];
    dv_d[0].quo  = '0;
    for (int i = 0; i < 3; i++) begin
      dv_d[0].rem[i]   = {1'b0, sq_d[SQ_STEPS].nmag[i][30:1]};
      dv_d[0].lo[i]    = {sq_d[SQ_STEPS].nmag[i][0], 30'd0};
      dv_d[0].rem[3+i] = sq_d[SQ_STEPS].rn[i][61:31];
      dv_d[0].lo[3+i]  = sq_d[SQ_STEPS].rn[i][30:0];
    end
  end
  assign dv_v[0] = sq_v[SQ_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    sbr_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (dv_v[k]),
      .in_d      (dv_d[k]),
      .out_valid (dv_v[k+1]),
      .out_d     (dv_d[k+1])
    );
  end

  sbr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (dv_v[DIV_STEPS]),
    .in_d      (dv_d[DIV_STEPS]),
    .center    (center_r),
    .damping   (damping_r),
    .out_valid (out_valid),
    .out_d     (res)
  );

  assign out_new_pos_x = res.new_pos[0];
  assign out_new_pos_y = res.new_pos[1];
  assign out_new_pos_z = res.new_pos[2];
  assign out_new_vel_x = res.new_vel[0];
  assign out_new_vel_y = res.new_vel[1];
  assign out_new_vel_z = res.new_vel[2];
  assign out_bounced   = res.bounced;

  `SBR_ASSERT_IMPL(a_bounce_needs_radius, out_valid && out_bounced, sph_rad_r != '0)
  `SBR_ASSERT_IMPL(a_zero_damping_stops, out_valid && out_bounced && damping_r == '0, out_new_vel_x == '0 && out_new_vel_y == '0 && out_new_vel_z == '0)
  `SBR_ASSERT_IMPL(a_stall_only_when_held, !in_ready, out_valid && !out_ready)
  `SBR_ASSERT_NEXT(a_damping_write, wr && paddr[4:2] == REG_DAMPING, damping_r == $past(pwdata[17:0]))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the sphere bounce block against a bit-exact Q16.16 predictor. The
// test drives directed corner particles, then streams of particles aimed
// into the sphere under several sphere settings. Both channels idle at
// random, and one long output stall fills the pipeline.
// ----------------------------------------------------------------------------
module tb;
  import sbr_pkg::*;

  localparam longint LIM31     = 64'sd1 << 31;
  localparam longint TWO30     = 64'sd1 << 30;
  localparam longint TWO29     = 64'sd1 << 29;
  localparam longint TWO16     = 64'sd1 << 16;
  localparam int     MAX_CYC   = 600000;
  localparam int     DRAIN_CYC = 90;
  localparam logic [2:0] REG_UNUSED = 3'd5;

  class sbr_scoreboard;
    longint ctr[3];
    longint rad;
    longint damp;
    out_t   expected_q[$];
    int     errors;

    function new();
      ctr = '{0, 0, 0};
      rad = 0;
      damp = 65536;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_CENTER_X: ctr[0] = longint'($signed(val));
        REG_CENTER_Y: ctr[1] = longint'($signed(val));
        REG_CENTER_Z: ctr[2] = longint'($signed(val));
        REG_RADIUS:   rad = longint'(val[30:0]);
        REG_DAMPING:  damp = longint'(val[17:0]);
        default: ;
      endcase
    endfunction

    function logic [31:0] clamp32(longint x);
      if (x > 64'sd2147483647) return 32'h7fff_ffff;
      if (x < -64'sd2147483648) return 32'h8000_0000;
      return x[31:0];
    endfunction

    function longint unsigned root64(longint unsigned x);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > x) bt >>= 2;
      while (bt != 0) begin
        if (x >= res + bt) begin
          x -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    // Work out the reflected particle and queue it.
    function void note_particle(logic [2:0][31:0] pos, logic [2:0][31:0] vel);
      longint p[3], v[3], n[3], u[3];
      longint unsigned r2;
      longint r, vn, w, q, s, t;
      bit hit;
      out_t o;
      hit = 0;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'($signed(pos[i]));
        v[i] = longint'($signed(vel[i]));
        n[i] = p[i] - ctr[i];
      end
      if (n[0] > -LIM31 && n[0] < LIM31 && n[1] > -LIM31 && n[1] < LIM31 &&
          n[2] > -LIM31 && n[2] < LIM31) begin
        r2 = longint'(n[0] * n[0]) + longint'(n[1] * n[1]) + longint'(n[2] * n[2]);
        if (longint'(rad * rad) > r2) begin
          s = n[0] * v[0] + n[1] * v[1];
          t = n[2] * v[2];
          hit = (s < -t);
        end
        if (hit) begin
          r = longint'(root64(r2));
          for (int i = 0; i < 3; i++) u[i] = (n[i] * TWO30) / r;
          vn = (v[0] * u[0] + v[1] * u[1] + v[2] * u[2]) / TWO30;
          for (int i = 0; i < 3; i++) begin
            w = v[i] - (vn * u[i]) / TWO29;
            q = (rad * n[i]) / r;
            o.new_pos[i] = clamp32(ctr[i] + q);
            o.new_vel[i] = clamp32((w * damp) / TWO16);
          end
        end
      end
      if (!hit) begin
        for (int i = 0; i < 3; i++) begin
          o.new_pos[i] = pos[i];
          o.new_vel[i] = vel[i];
        end
      end
      o.bounced = hit;
      expected_q.push_back(o);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        report("result with no pending particle");
        return;
      end
      exp = expected_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.new_pos[i] !== exp.new_pos[i])
          report($sformatf("new_pos[%0d] got %h exp %h", i, got.new_pos[i],
                           exp.new_pos[i]));
        if (got.new_vel[i] !== exp.new_vel[i])
          report($sformatf("new_vel[%0d] got %h exp %h", i, got.new_vel[i],
                           exp.new_vel[i]));
      end
      if (got.bounced !== exp.bounced)
        report($sformatf("bounced got %b exp %b", got.bounced, exp.bounced));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 0;
  logic        in_ready;
  logic [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [31:0] in_vel_x = '0, in_vel_y = '0, in_vel_z = '0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic        out_bounced;

  sbr_scoreboard sb = new();
  bit idling_on = 1;
  bit long_hold_req = 0;
  int cycles = 0;

  sphere_bounce_reflect_top u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYC) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: check, then pick out_ready for the next cycle.
  initial begin
    int hold;
    out_t got;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.new_pos = {out_new_pos_z, out_new_pos_y, out_new_pos_x};
        got.new_vel = {out_new_vel_z, out_new_vel_y, out_new_vel_x};
        got.bounced = out_bounced;
        sb.check_result(got);
      end
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 300;
      end else if (hold == 0 && idling_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 5);
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                            logic [31:0] rad, logic [31:0] damp);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_CENTER_Z, cz);
    cfg_write(REG_RADIUS, rad);
    cfg_write(REG_DAMPING, damp);
  endtask

  task automatic send_particle(logic [2:0][31:0] pos, logic [2:0][31:0] vel);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_pos_z, in_pos_y, in_pos_x} <= pos;
    {in_vel_z, in_vel_y, in_vel_x} <= vel;
    do @(posedge clk); while (!in_ready);
    sb.note_particle(pos, vel);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // Mostly particles placed inside the sphere and headed inward.
  task automatic random_particles(int count);
    logic [2:0][31:0] pos, vel;
    longint bound, n;
    int sh;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0) begin
        pos = {$urandom, $urandom, $urandom};
        vel = {$urandom, $urandom, $urandom};
      end else begin
        bound = (sb.rad > 2) ? sb.rad / 2 : 1;
        sh = $urandom_range(0, 12);
        for (int i = 0; i < 3; i++) begin
          n = longint'($urandom_range(0, 2 * bound)) - bound;
          pos[i] = 32'(sb.ctr[i] + n);
          vel[i] = 32'(-(n >>> sh) + $signed($urandom_range(0, 2000)) - 1000);
        end
      end
      send_particle(pos, vel);
    end
  endtask

  initial begin
    logic [31:0] cx, cy, cz;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sphere has radius 0: extremes pass straight through.
    send_particle({3{32'h7fff_ffff}}, {3{32'h7fff_ffff}});
    send_particle({3{32'h8000_0000}}, {3{32'h8000_0000}});
    send_particle('0, '0);
    wait_drained();

    set_sphere(32'd0, 32'd0, 32'd0, 32'd65536, 32'd65536);
    cfg_write(REG_UNUSED, 32'hdead_beef);
    send_particle('0, {32'd5, 32'd7, 32'd9});                        // at center
    send_particle({32'd0, 32'd0, 32'd65536}, {32'd0, 32'd0, -32'sd4});  // on surface
    send_particle({32'd0, 32'd0, 32'd32768}, {32'd0, 32'd0, -32'sd4});  // inside, inward
    send_particle({32'd0, 32'd0, 32'd32768}, {32'd0, 32'd0, 32'd4});    // inside, outward
    send_particle({32'd100, -32'sd200, 32'd300}, {-32'sd9, 32'd9, -32'sd9});
    send_particle({32'h8000_0000, 32'd0, 32'd0}, {32'h7fff_ffff, 32'd0, 32'd0});
    send_particle({32'd1, 32'd1, 32'd1}, {3{32'h8000_0000}});
    send_particle({32'd1, 32'd0, 32'd0}, {32'h8000_0000, 32'd0, 32'd0});
    random_particles(280);
    wait_drained();

    set_sphere($urandom_range(0, 2 ** 21) - 2 ** 20, $urandom_range(0, 2 ** 21) - 2 ** 20,
               $urandom_range(0, 2 ** 21) - 2 ** 20, $urandom_range(1, 2 ** 24),
               $urandom_range(0, 131072));
    random_particles(100);
    long_hold_req = 1;
    random_particles(200);
    wait_drained();

    // Far corners: big sphere, center x and y at the range limits, damping 2.0.
    set_sphere(32'h7fff_ffff, 32'h8000_0000, 32'd0, 32'h7fff_ffff, 32'd131072);
    random_particles(280);
    wait_drained();

    set_sphere($urandom, $urandom, $urandom, 32'd0, 32'd0);
    random_particles(150);
    wait_drained();

    set_sphere(32'd0, 32'd0, 32'd0, 32'h7fff_ffff, 32'h0003_ffff);
    random_particles(280);
    wait_drained();

    cx = $urandom_range(0, 2 ** 25) - 2 ** 24;
    cy = $urandom_range(0, 2 ** 25) - 2 ** 24;
    cz = $urandom_range(0, 2 ** 25) - 2 ** 24;
    set_sphere(cx, cy, cz, $urandom_range(2, 2 ** 20), $urandom_range(0, 131072));
    random_particles(200);
    idling_on = 0;
    random_particles(250);
    wait_drained();

    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// File: sphere_bounce_reflect_top.f
+incdir+design
design/sbr_pkg.sv
design/sbr_front.sv
design/sbr_sqrt_stage.sv
design/sbr_div_stage.sv
design/sbr_back.sv
design/sphere_bounce_reflect_top.sv
tb/tb.sv
